[hw/rtl/dmst_pkg.sv]
package dmst_pkg;

    localparam int KEY_W = 64;
    localparam int VAL_W = 64;
    localparam int CNT_W = 32;
    localparam int CMD_W = 2;

    // Command codes; the fourth code is ignored and answered with the counters
    localparam logic [CMD_W-1:0] CMD_PROBE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STORE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic accept;   // command word taken this cycle
        logic lookup;   // probe read data is on the memory outputs
        logic wipe_we;  // clearing pass writes one value entry
    } dmst_ctl_t;

endpackage

[hw/rtl/dmst_ram.sv]
module dmst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/dmst_ctrl.sv]
module dmst_ctrl
    import dmst_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [CMD_W-1:0]           command,
    output logic                       busy,
    output dmst_ctl_t                  ctl,
    output logic [$clog2(ENTRIES)-1:0] wipe_addr
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_WIPE
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] wipe_addr_reg;
    logic             accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WIPE;
            wipe_addr_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && command == CMD_PROBE)
                    begin
                        state_reg <= ST_LOOKUP;
                    end
                    else if (accept && command == CMD_CLEAR)
                    begin
                        state_reg     <= ST_WIPE;
                        wipe_addr_reg <= '0;
                    end
                end
                ST_LOOKUP:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_WIPE:
                begin
                    // advance one entry a cycle, leave after the last one
                    wipe_addr_reg <= wipe_addr_reg + IDX_W'(1);
                    if (wipe_addr_reg == LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign ctl.accept  = accept;
    assign ctl.lookup  = (state_reg == ST_LOOKUP);
    assign ctl.wipe_we = (state_reg == ST_WIPE);
    assign wipe_addr   = wipe_addr_reg;

endmodule

[hw/rtl/direct_mapped_signature_table.sv]
// Direct-mapped table of 64-bit key/value pairs with probe statistics.
//
// Command channel: drive command, key and store_value with start high; the
// word is taken at the rising edge where start is high and busy is low.
// The entry is chosen by the low key bits (key & (ENTRIES - 1)).
// Result channel: done is high for exactly one cycle with found_value, hit,
// collision and the three counters after the command. The receiver cannot
// stall, so every result must be taken in the cycle it is shown.
// Sequence per command word:
//   probe        the key and value memories are read into their registers,
//                then the result stage compares and updates the counters.
//   store/other  done follows the accepting edge.
//   clear        done follows at once with zero counters, then busy holds
//                while all ENTRIES entries of the value memory are swept one
//                entry a cycle (the value memory has a single write port).
// Reset: counters clear at once and the same sweep runs with busy high
// before the first word is taken. Key memory is never cleared; an entry
// with a zero value is empty whatever key it holds.
module direct_mapped_signature_table
    import dmst_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [CMD_W-1:0] command,
    input  logic [KEY_W-1:0] key,
    input  logic [VAL_W-1:0] store_value,
    output logic             done,
    output logic [VAL_W-1:0] found_value,
    output logic             hit,
    output logic             collision,
    output logic [CNT_W-1:0] probe_count,
    output logic [CNT_W-1:0] hit_count,
    output logic [CNT_W-1:0] collision_count
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(ENTRIES - 1);

    dmst_ctl_t        ctl;
    logic [IDX_W-1:0] wipe_addr;
    logic [IDX_W-1:0] slot;
    logic             do_store;
    logic             do_probe;

    logic             val_we;
    logic [IDX_W-1:0] val_waddr;
    logic [VAL_W-1:0] val_wdata;
    logic [VAL_W-1:0] val_rdata;
    logic [KEY_W-1:0] key_rdata;

    logic [KEY_W-1:0] probe_key_reg;
    logic             occupied;
    logic             match;

    logic             done_reg;
    logic [VAL_W-1:0] found_reg;
    logic             hit_reg;
    logic             coll_reg;
    logic [CNT_W-1:0] probes_reg;
    logic [CNT_W-1:0] hits_reg;
    logic [CNT_W-1:0] colls_reg;

    dmst_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .busy      (busy),
        .ctl       (ctl),
        .wipe_addr (wipe_addr)
    );

    assign slot     = key[IDX_W-1:0] & IDX_MASK;
    assign do_store = ctl.accept && (command == CMD_STORE);
    assign do_probe = ctl.accept && (command == CMD_PROBE);

    // Value memory: the clearing pass owns the write port while it runs
    assign val_we    = ctl.wipe_we || do_store;
    assign val_waddr = ctl.wipe_we ? wipe_addr : slot;
    assign val_wdata = ctl.wipe_we ? '0 : store_value;

    dmst_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .re    (do_probe),
        .raddr (slot),
        .rdata (val_rdata)
    );

    dmst_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (do_store),
        .waddr (slot),
        .wdata (key),
        .re    (do_probe),
        .raddr (slot),
        .rdata (key_rdata)
    );

    // Hold the probe key for the compare in the cycle after the read
    always_ff @(posedge clk)
    begin
        if (do_probe)
        begin
            probe_key_reg <= key;
        end
    end

    // A write never lands in a probe's read cycle, so no forwarding is needed
    assign occupied = (val_rdata != '0);
    assign match    = (key_rdata == probe_key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            coll_reg   <= 1'b0;
            probes_reg <= '0;
            hits_reg   <= '0;
            colls_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.lookup)
            begin
                // finish the probe: count it and classify the entry
                done_reg   <= 1'b1;
                hit_reg    <= occupied && match;
                coll_reg   <= occupied && !match;
                probes_reg <= probes_reg + CNT_W'(1);
                if (occupied && match)
                begin
                    hits_reg <= hits_reg + CNT_W'(1);
                end
                if (occupied && !match)
                begin
                    colls_reg <= colls_reg + CNT_W'(1);
                end
            end
            else if (ctl.accept && command != CMD_PROBE)
            begin
                done_reg <= 1'b1;
                hit_reg  <= 1'b0;
                coll_reg <= 1'b0;
                if (command == CMD_CLEAR)
                begin
                    probes_reg <= '0;
                    hits_reg   <= '0;
                    colls_reg  <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.lookup)
        begin
            found_reg <= (occupied && match) ? val_rdata : '0;
        end
        else if (ctl.accept && command != CMD_PROBE)
        begin
            found_reg <= '0;
        end
    end

    assign done            = done_reg;
    assign found_value     = found_reg;
    assign hit             = hit_reg;
    assign collision       = coll_reg;
    assign probe_count     = probes_reg;
    assign hit_count       = hits_reg;
    assign collision_count = colls_reg;

    a_probe_latency: assert property (@(posedge clk) disable iff (!rst_n)
        do_probe |-> ##2 done)
        else $error("probe result not delivered two cycles after accept");

    a_clear_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.accept && command == CMD_CLEAR) |=> busy && done && probe_count == '0)
        else $error("clear did not start sweep with zeroed counters");

    a_hit_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> hit_count == $past(hit_count) + CNT_W'(1))
        else $error("hit not counted");

    a_hit_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> found_value == '0)
        else $error("value returned without a hit");

    a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && collision))
        else $error("hit and collision both set");

endmodule
